// ----- design/dcab_pkg.sv -----
// shared types, constants and answer record table for the captive dns answer builder
`default_nettype none
package dcab_pkg;

	// frame size limit default
	localparam int unsigned MAX_FRAME_BYTES_DEF = 512;

	// config register reset values
	localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
	localparam logic [31:0] TTL_RESET  = 32'd60;

	// config register indexes
	localparam logic CFG_ADDR = 1'b0;
	localparam logic CFG_TTL  = 1'b1;

	// header layout
	localparam int unsigned HDR_LAST_POS = 11;
	localparam int unsigned FLAGS_HI_POS = 2;
	localparam int unsigned FLAGS_LO_POS = 3;
	localparam int unsigned ANCNT_HI_POS = 6;
	localparam int unsigned ANCNT_LO_POS = 7;
	localparam logic [7:0] FLAGS_HI = 8'h84;
	localparam logic [7:0] FLAGS_LO = 8'h00;
	localparam logic [7:0] ANCNT_HI = 8'h00;
	localparam logic [7:0] ANCNT_LO = 8'h01;

	// qtype plus qclass bytes after the name
	localparam logic [2:0] TAIL_BYTES = 3'd4;

	// index of the final byte of the 16-byte answer record
	localparam logic [3:0] REC_LAST_IDX = 4'd15;

	// frame status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT_HDR = 2'd1,
		ST_QUEST_END = 2'd2,
		ST_OVERSIZE  = 2'd3
	} status_t;

	// one parsed byte handed from parser to emitter
	typedef struct packed {
		logic       emit;
		logic [7:0] val;
		logic       last;
		status_t    status;
	} item_t;

	// answer record byte: name pointer, type A, class IN, ttl, rdlength, address
	function automatic logic [7:0] rec_byte(input logic [3:0] idx, input logic [31:0] ttl,
			input logic [31:0] addr);
		logic [7:0] b;
		b = 8'h00;
		unique case (idx)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h00;
			4'd5:    b = 8'h01;
			4'd6:    b = ttl[31:24];
			4'd7:    b = ttl[23:16];
			4'd8:    b = ttl[15:8];
			4'd9:    b = ttl[7:0];
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h04;
			4'd12:   b = addr[31:24];
			4'd13:   b = addr[23:16];
			4'd14:   b = addr[15:8];
			default: b = addr[7:0];
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ----- design/dcab_parser.sv -----
// query parser: header rewrite, name walk, tail pass and error detection per byte
`default_nettype none
module dcab_parser #(
	parameter int unsigned MAX_FRAME_BYTES = dcab_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output      logic           s_tready,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           s_tlast,
	output      logic           item_valid,
	output      dcab_pkg::item_t item,
	input  wire logic           item_take
);

	localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_TAIL   = 2'd2,
		PH_DROP   = 2'd3
	} phase_t;

	logic [PosW-1:0] pos_q, pos_d;
	phase_t          phase_q, phase_d;
	logic [7:0]      skip_q, skip_d;
	logic [2:0]      tail_q, tail_d, tail_dec;
	logic            done_q, done_d;
	logic            over;
	logic            acc;
	dcab_pkg::item_t item_d;
	dcab_pkg::item_t item_s1;
	logic            valid_s1;

	assign s_tready   = !valid_s1 || item_take;
	assign acc        = s_tvalid && s_tready;
	assign item_valid = valid_s1;
	assign item       = item_s1;
	assign over       = pos_q >= MaxPos;
	assign tail_dec   = (tail_q != 3'd0) ? tail_q - 3'd1 : tail_q;

	// per byte parse step
	always_comb begin
		pos_d       = pos_q;
		phase_d     = phase_q;
		skip_d      = skip_q;
		tail_d      = tail_q;
		done_d      = done_q;
		item_d.emit = 1'b0;
		item_d.val  = s_tdata;
		item_d.last = s_tlast;
		if (!over) begin
			unique case (phase_q)
				PH_HEADER: begin
					item_d.emit = 1'b1;
					if (pos_q == PosW'(dcab_pkg::FLAGS_HI_POS)) item_d.val = dcab_pkg::FLAGS_HI;
					else if (pos_q == PosW'(dcab_pkg::FLAGS_LO_POS)) item_d.val = dcab_pkg::FLAGS_LO;
					else if (pos_q == PosW'(dcab_pkg::ANCNT_HI_POS)) item_d.val = dcab_pkg::ANCNT_HI;
					else if (pos_q == PosW'(dcab_pkg::ANCNT_LO_POS)) item_d.val = dcab_pkg::ANCNT_LO;
					if (pos_q >= PosW'(dcab_pkg::HDR_LAST_POS)) phase_d = PH_NAME;
				end
				PH_NAME: begin
					item_d.emit = 1'b1;
					if (skip_q != 8'd0) begin
						skip_d = skip_q - 8'd1;
					end else if (s_tdata == 8'd0) begin
						phase_d = PH_TAIL;
						tail_d  = dcab_pkg::TAIL_BYTES;
					end else begin
						skip_d = s_tdata;
					end
				end
				PH_TAIL: begin
					item_d.emit = 1'b1;
					tail_d      = tail_dec;
					if (tail_dec == 3'd0) begin
						phase_d = PH_DROP;
						done_d  = 1'b1;
					end
				end
				PH_DROP: begin
				end
			endcase
			pos_d = pos_q + PosW'(1);
		end
		// frame status, oversize first, then short header, then incomplete question
		priority if (over) item_d.status = dcab_pkg::ST_OVERSIZE;
		else if (pos_q < PosW'(dcab_pkg::HDR_LAST_POS)) item_d.status = dcab_pkg::ST_SHORT_HDR;
		else if (!done_d) item_d.status = dcab_pkg::ST_QUEST_END;
		else item_d.status = dcab_pkg::ST_OK;
	end

	// parse state, cleared after each last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			skip_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				pos_q   <= '0;
				phase_q <= PH_HEADER;
				skip_q  <= '0;
				tail_q  <= '0;
				done_q  <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				phase_q <= phase_d;
				skip_q  <= skip_d;
				tail_q  <= tail_d;
				done_q  <= done_d;
			end
		end
	end

	// stage register toward the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) item_s1 <= item_d;
	end

endmodule
`default_nettype wire

// ----- design/dcab_emitter.sv -----
// output stage: byte results, error result and the answer record burst
`default_nettype none
module dcab_emitter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire dcab_pkg::item_t item,
	output      logic            item_take,
	input  wire logic [31:0]     answer_address,
	input  wire logic [31:0]     answer_ttl,
	output      logic            m_tvalid,
	input  wire logic            m_tready,
	output      logic [7:0]      m_tdata,
	output      logic            m_tlast,
	output      logic [1:0]      m_tuser
);

	logic            out_valid_q;
	logic [7:0]      data_q;
	logic            last_q;
	logic [1:0]      status_q;
	logic            burst_q;
	logic [3:0]      idx_q;
	logic            load_ok;
	logic            nx_valid;
	logic [7:0]      nx_data;
	logic            nx_last;
	logic [1:0]      nx_status;
	logic            nx_burst;
	logic [3:0]      nx_idx;

	assign load_ok   = !out_valid_q || m_tready;
	assign item_take = load_ok && !burst_q;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = data_q;
	assign m_tlast   = last_q;
	assign m_tuser   = status_q;

	// choose the next result beat
	always_comb begin
		nx_valid  = 1'b0;
		nx_data   = 8'h00;
		nx_last   = 1'b0;
		nx_status = dcab_pkg::ST_OK;
		nx_burst  = burst_q;
		nx_idx    = idx_q;
		if (burst_q) begin
			nx_valid = 1'b1;
			nx_data  = dcab_pkg::rec_byte(idx_q, answer_ttl, answer_address);
			nx_last  = idx_q == dcab_pkg::REC_LAST_IDX;
			nx_burst = idx_q != dcab_pkg::REC_LAST_IDX;
			nx_idx   = idx_q + 4'd1;
		end else if (item_valid) begin
			if (item.last && item.status != dcab_pkg::ST_OK) begin
				// error frame: single zero beat carrying the status
				nx_valid  = 1'b1;
				nx_last   = 1'b1;
				nx_status = item.status;
			end else if (item.last) begin
				// answer: optional final query byte, then the record
				nx_valid = 1'b1;
				nx_burst = 1'b1;
				if (item.emit) begin
					nx_data = item.val;
					nx_idx  = 4'd0;
				end else begin
					nx_data = dcab_pkg::rec_byte(4'd0, answer_ttl, answer_address);
					nx_idx  = 4'd1;
				end
			end else if (item.emit) begin
				nx_valid = 1'b1;
				nx_data  = item.val;
			end
		end
	end

	// output register and burst counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 1'b0;
			idx_q       <= '0;
		end else if (load_ok) begin
			out_valid_q <= nx_valid;
			burst_q     <= nx_burst;
			idx_q       <= nx_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			data_q   <= nx_data;
			last_q   <= nx_last;
			status_q <= nx_status;
		end
	end

endmodule
`default_nettype wire

// ----- design/dns_captive_answer_builder_top.sv -----
// top level of the captive dns answer builder: config registers, parser and emitter
//
// Takes a DNS query one byte per beat and streams back the response: header with
// flags 0x8400 and answer count 1, the question through QTYPE/QCLASS, later bytes
// dropped, and at the last beat a 16-byte A record holding answer_ttl and
// answer_address. One byte is accepted every cycle unless the output backs up; at
// each good frame end the input can stall while the output register drains the
// record, one byte per cycle while m_tready is high (the last query byte, when
// passed on, goes out ahead of the record). Results pass through the parser
// stage register and then the output register. A bad frame ends with one beat of
// data 0, tlast 1 and the status in m_tuser (1 short header, 2 question past
// end, 3 oversize); bytes already sent for it are void.
// Config writes are taken at any time but are meant only while the block is idle.
`default_nettype none
module dns_captive_answer_builder_top #(
	parameter int unsigned MAX_FRAME_BYTES = dcab_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // data_in
	input  wire logic        s_tlast,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // data_out
	output      logic        m_tlast,
	output      logic [1:0]  m_tuser,   // status
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0]     answer_address_q;
	logic [31:0]     answer_ttl_q;
	logic            item_valid;
	logic            item_take;
	dcab_pkg::item_t item;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_address_q <= dcab_pkg::ADDR_RESET;
			answer_ttl_q     <= dcab_pkg::TTL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dcab_pkg::CFG_ADDR: answer_address_q <= cfg_data;
				dcab_pkg::CFG_TTL:  answer_ttl_q     <= cfg_data;
				default:            answer_ttl_q     <= answer_ttl_q;
			endcase
		end
	end

	dcab_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take)
	);

	dcab_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take),
		.answer_address(answer_address_q),
		.answer_ttl    (answer_ttl_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser)
	);

endmodule
`default_nettype wire
